// ===== src/wfqw_pkg.sv =====
// Package: shared types and constants of the wheel feedback quality weighting core.
`default_nettype none
package wfqw_pkg;

   localparam int unsigned QW = 16;                 // Q15 weight width (32768 fits)
   localparam logic [QW-1:0] Q_ONE = 16'h8000;       // 1.0 in Q15

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_RPM_THR  = 3'd1;
   localparam logic [2:0] CSR_CUR_THR  = 3'd2;
   localparam logic [2:0] CSR_DUTY_THR = 3'd3;
   localparam logic [2:0] CSR_MIN_WGT  = 3'd4;

   // Controller ids
   localparam logic [7:0] ID_DRIVE_LO = 8'h50;
   localparam logic [7:0] ID_DRIVE_HI = 8'h53;
   localparam logic [7:0] ID_STEER_0  = 8'h60;
   localparam logic [7:0] ID_STEER_1  = 8'h61;
   localparam logic [7:0] ID_STEER_3  = 8'h62;
   localparam logic [7:0] ID_STEER_2  = 8'h63;

   typedef struct packed {
      logic        [7:0]  device_id;
      logic signed [31:0] electrical_rpm;
      logic signed [15:0] motor_current;
      logic signed [15:0] duty_q15;
   } req_type;

   typedef struct packed {
      logic          id_recognized;
      logic [1:0]    wheel_num;
      logic [QW-1:0] item_quality;
      logic [QW-1:0] weight_wheel0;
      logic [QW-1:0] weight_wheel1;
      logic [QW-1:0] weight_wheel2;
      logic [QW-1:0] weight_wheel3;
   } rsp_type;

   // Operands of the quality quotient: q*ct*e / (e*m + b*ct), m = max(|i|, ct)
   typedef struct packed {
      logic [14:0] ct;
      logic [14:0] e;
      logic [15:0] m;
      logic [14:0] b;
   } op_type;

endpackage
`default_nettype wire

// ===== src/wheel_feedback_quality_weighting_core.sv =====
// Top level: status report decode, quality scoring and per-wheel weight store.
`default_nettype none
//
//  Channel   Ports                              Direction  Transaction
//  --------  ---------------------------------  ---------  ---------------------------------
//  request   req_valid / req_ready / req_data    in         one motor-controller status report
//  response  rsp_valid / rsp_ready / rsp_data    out        quality and four combined weights
//  csr       csr_wr_en / csr_index / csr_wdata   in         register write, no wait, no read
//
//  Scored report: decode, 15 multiply and 16 divide steps in wfqw_muldiv, quotient
//  pickup and response load, in that order; no new report is taken until back in idle.
//  Unknown ids and full-quality reports skip wfqw_muldiv: decode, then response load.
//  A finished result waits in the response register; with rsp_ready low the core
//  holds in its finish state and req_ready stays low until the register frees up.
//  Synchronous active-high reset restores register defaults and all weights to 1.0.
//
module wheel_feedback_quality_weighting_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wfqw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wfqw_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import wfqw_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PREP   = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // ---------------- configuration registers ----------------
   logic          enable_ff;
   logic [31:0]   rpm_thr_ff;
   logic [14:0]   cur_thr_ff;
   logic [14:0]   duty_thr_ff;
   logic [QW-1:0] min_wgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         rpm_thr_ff  <= 32'd1000;
         cur_thr_ff  <= 15'd3000;
         duty_thr_ff <= 15'd29491;
         min_wgt_ff  <= 16'd3277;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_RPM_THR:  rpm_thr_ff  <= csr_wdata;
            CSR_CUR_THR:  cur_thr_ff  <= csr_wdata[14:0];
            CSR_DUTY_THR: duty_thr_ff <= csr_wdata[14:0];
            CSR_MIN_WGT:  min_wgt_ff  <= csr_wdata[15:0];
            default: ;  // indexes past the list are ignored
         endcase
      end
   end

   // ---------------- control and held report ----------------
   logic [1:0]    state_ff, state_in;
   req_type       req_ff;
   logic          known_ff, known_in;
   logic          drive_ff, drive_in;
   logic [1:0]    wheel_ff, wheel_in;
   logic [QW-1:0] qual_ff, qual_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [QW-1:0] drive_wgt_ff [4];
   logic [QW-1:0] steer_wgt_ff [4];
   logic [QW-1:0] drive_wgt_in [4];
   logic [QW-1:0] steer_wgt_in [4];

   logic          start;
   op_type        op;
   logic          md_done;
   logic [15:0]   md_quot;

   // ---------------- decode and operand prep ----------------
   logic          id_known, id_drive;
   logic [1:0]    id_wheel;
   logic [31:0]   rpm_mag;
   logic [15:0]   cur_mag;
   logic [15:0]   duty_abs;
   logic [14:0]   duty_mag;
   logic [14:0]   ct, dt;
   logic [15:0]   e_full;
   logic [QW-1:0] lo_wgt;
   logic [QW-1:0] clamped;
   logic          load_rsp;

   always_comb begin
      id_known = 1'b1;
      id_drive = 1'b0;
      id_wheel = 2'd0;
      priority if (req_ff.device_id >= ID_DRIVE_LO && req_ff.device_id <= ID_DRIVE_HI) begin
         id_drive = 1'b1;
         id_wheel = req_ff.device_id[1:0];
      end else if (req_ff.device_id == ID_STEER_0) begin
         id_wheel = 2'd0;
      end else if (req_ff.device_id == ID_STEER_1) begin
         id_wheel = 2'd1;
      end else if (req_ff.device_id == ID_STEER_3) begin
         id_wheel = 2'd3;
      end else if (req_ff.device_id == ID_STEER_2) begin
         id_wheel = 2'd2;
      end else begin
         id_known = 1'b0;
      end

      // two's complement magnitudes; the most negative code maps to 2^(w-1)
      rpm_mag  = req_ff.electrical_rpm[31] ? (32'd0 - req_ff.electrical_rpm)
                                           : req_ff.electrical_rpm;
      cur_mag  = req_ff.motor_current[15] ? (16'd0 - req_ff.motor_current)
                                          : req_ff.motor_current;
      duty_abs = req_ff.duty_q15[15] ? (16'd0 - req_ff.duty_q15)
                                     : req_ff.duty_q15;
      duty_mag = duty_abs[15] ? 15'h7FFF : duty_abs[14:0];

      ct     = (cur_thr_ff == 15'd0) ? 15'd1 : cur_thr_ff;
      dt     = (duty_thr_ff == 15'd0) ? 15'd1 : duty_thr_ff;
      e_full = Q_ONE - {1'b0, dt};

      op.ct = ct;
      op.e  = e_full[14:0];
      op.m  = (cur_mag > {1'b0, ct}) ? cur_mag : {1'b0, ct};  // ct + max(0, |i| - ct)
      op.b  = (duty_mag > dt) ? (duty_mag - dt) : 15'd0;

      lo_wgt  = (min_wgt_ff > Q_ONE) ? Q_ONE : min_wgt_ff;
      clamped = (md_quot < lo_wgt) ? lo_wgt : md_quot;
   end

   wfqw_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (op),
      .done  (md_done),
      .quot  (md_quot)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      known_in = known_ff;
      drive_in = drive_ff;
      wheel_in = wheel_ff;
      qual_in  = qual_ff;
      start    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            known_in = id_known;
            drive_in = id_drive;
            wheel_in = id_wheel;
            priority if (!id_known) begin
               qual_in  = '0;
               state_in = ST_FINISH;
            end else if (!enable_ff || rpm_mag >= rpm_thr_ff) begin
               qual_in  = Q_ONE;
               state_in = ST_FINISH;
            end else begin
               start    = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (md_done) begin
               qual_in  = clamped;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // weight store update and combined (min) weights of the outgoing transaction
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         drive_wgt_in[i] = drive_wgt_ff[i];
         steer_wgt_in[i] = steer_wgt_ff[i];
      end
      if (load_rsp && known_ff) begin
         if (drive_ff) drive_wgt_in[wheel_ff] = qual_ff;
         else          steer_wgt_in[wheel_ff] = qual_ff;
      end

      rsp_in = rsp_ff;
      if (load_rsp) begin
         rsp_in.id_recognized = known_ff;
         rsp_in.wheel_num     = known_ff ? wheel_ff : 2'd0;
         rsp_in.item_quality  = qual_ff;
         rsp_in.weight_wheel0 = (drive_wgt_in[0] < steer_wgt_in[0]) ? drive_wgt_in[0]
                                                                    : steer_wgt_in[0];
         rsp_in.weight_wheel1 = (drive_wgt_in[1] < steer_wgt_in[1]) ? drive_wgt_in[1]
                                                                    : steer_wgt_in[1];
         rsp_in.weight_wheel2 = (drive_wgt_in[2] < steer_wgt_in[2]) ? drive_wgt_in[2]
                                                                    : steer_wgt_in[2];
         rsp_in.weight_wheel3 = (drive_wgt_in[3] < steer_wgt_in[3]) ? drive_wgt_in[3]
                                                                    : steer_wgt_in[3];
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            drive_wgt_ff[i] <= Q_ONE;
            steer_wgt_ff[i] <= Q_ONE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            drive_wgt_ff[i] <= drive_wgt_in[i];
            steer_wgt_ff[i] <= steer_wgt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      known_ff <= known_in;
      drive_ff <= drive_in;
      wheel_ff <= wheel_in;
      qual_ff  <= qual_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== src/wfqw_muldiv.sv =====
// Bit-serial multiply then restoring divide for the quality quotient.
`default_nettype none
module wfqw_muldiv (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  wfqw_pkg::op_type op,
   output logic            done,
   output logic [15:0]     quot
);
   import wfqw_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [14:0] ct_ff, ct_in;
   logic [15:0] m_ff, m_in;
   logic [14:0] e_sh_ff, e_sh_in;
   logic [14:0] b_sh_ff, b_sh_in;
   logic [29:0] p_ff, p_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;

   logic [29:0] p_step;
   logic [31:0] den_step;
   logic [32:0] trial;
   logic [32:0] diff;

   // MSB-first shift-add: P = ct*e, den = e*m + b*ct
   always_comb begin
      p_step   = {p_ff[28:0], 1'b0} + (e_sh_ff[14] ? {15'd0, ct_ff} : 30'd0);
      den_step = {den_ff[30:0], 1'b0}
               + (e_sh_ff[14] ? {16'd0, m_ff} : 32'd0)
               + (b_sh_ff[14] ? {17'd0, ct_ff} : 32'd0);
      trial    = (cnt_ff == 4'd0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff     = trial - {1'b0, den_ff};
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      ct_in    = ct_ff;
      m_in     = m_ff;
      e_sh_in  = e_sh_ff;
      b_sh_in  = b_sh_ff;
      p_in     = p_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_MUL;
               cnt_in   = 4'd0;
               ct_in    = op.ct;
               m_in     = op.m;
               e_sh_in  = op.e;
               b_sh_in  = op.b;
               p_in     = '0;
               den_in   = '0;
            end
         end
         PH_MUL: begin
            p_in    = p_step;
            den_in  = den_step;
            e_sh_in = {e_sh_ff[13:0], 1'b0};
            b_sh_in = {b_sh_ff[13:0], 1'b0};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd14) begin
               phase_in = PH_DIV;
               cnt_in   = 4'd0;
               rem_in   = {2'b00, p_step};
               quot_in  = '0;
            end
         end
         PH_DIV: begin
            // first step weighs 2^15 (P <= den), then one quotient bit per cycle
            if (!diff[32]) begin
               rem_in  = diff[31:0];
               quot_in = {quot_ff[14:0], 1'b1};
            end else begin
               rem_in  = trial[31:0];
               quot_in = {quot_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ct_ff   <= ct_in;
      m_ff    <= m_in;
      e_sh_ff <= e_sh_in;
      b_sh_ff <= b_sh_in;
      p_ff    <= p_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// ===== tb/wheel_feedback_quality_weighting_core_tb.sv =====
// Testbench: directed and random status reports against a predictor of the wheel weight core.
`timescale 1ns / 100ps

module wheel_feedback_quality_weighting_core_tb;
   import wfqw_pkg::*;

   // 1.0 in Q15 as a plain integer, for the predictor's wide arithmetic
   localparam longint unsigned SCALE = 32768;

   // ------------------------------------------------------------------------
   // Scoreboard: register shadow, per-wheel weight store, expected results.
   // ------------------------------------------------------------------------
   class wheel_weight_tracker;
      logic        enable_w;
      logic [31:0] rpm_thr;
      logic [14:0] cur_thr;
      logic [14:0] duty_thr;
      logic [15:0] min_wgt;
      logic [15:0] drive_wgt [4];
      logic [15:0] steer_wgt [4];
      rsp_type     expected_weights [$];
      int          mismatches;

      function new();
         enable_w = 1'b1;
         rpm_thr  = 32'd1000;
         cur_thr  = 15'd3000;
         duty_thr = 15'd29491;
         min_wgt  = 16'd3277;
         foreach (drive_wgt[i]) begin
            drive_wgt[i] = Q_ONE;
            steer_wgt[i] = Q_ONE;
         end
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_ENABLE:   enable_w = data[0];
            CSR_RPM_THR:  rpm_thr  = data;
            CSR_CUR_THR:  cur_thr  = data[14:0];
            CSR_DUTY_THR: duty_thr = data[14:0];
            CSR_MIN_WGT:  min_wgt  = data[15:0];
            default: ;   // indexes past the list are dropped
         endcase
      endfunction

      // Q15 quality of one report; exact integer quotient, then floor clamp
      function logic [15:0] predict_quality(req_type r);
         longint          rpm_v, cur_v, duty_v;
         longint unsigned ct, dt, e, a, b, lo, qv;
         if (!enable_w) return Q_ONE;
         rpm_v = longint'($signed(r.electrical_rpm));
         if (rpm_v < 0) rpm_v = -rpm_v;
         if (rpm_v >= longint'({32'd0, rpm_thr})) return Q_ONE;
         cur_v  = longint'($signed(r.motor_current));
         duty_v = longint'($signed(r.duty_q15));
         if (cur_v < 0) cur_v = -cur_v;
         if (duty_v < 0) duty_v = -duty_v;
         if (duty_v > 32767) duty_v = 32767;   // duty magnitude saturates
         ct = (cur_thr == 0) ? 1 : cur_thr;
         dt = (duty_thr == 0) ? 1 : duty_thr;
         e  = SCALE - dt;
         a  = (cur_v > ct) ? cur_v - ct : 0;
         b  = (duty_v > dt) ? duty_v - dt : 0;
         qv = (SCALE * ct * e) / (ct * e + a * e + b * ct);
         lo = (min_wgt > Q_ONE) ? SCALE : min_wgt;
         if (qv < lo) qv = lo;
         if (qv > SCALE) qv = SCALE;
         return 16'(qv);
      endfunction

      function logic [15:0] combined(int w);
         return (drive_wgt[w] < steer_wgt[w]) ? drive_wgt[w] : steer_wgt[w];
      endfunction

      function void note_report(req_type r);
         rsp_type     want;
         logic [15:0] qv;
         logic [1:0]  wheel;
         logic        known;
         logic        drive;
         known = 1'b1;
         drive = 1'b0;
         wheel = 2'd0;
         qv    = 16'd0;
         if (r.device_id >= ID_DRIVE_LO && r.device_id <= ID_DRIVE_HI) begin
            drive = 1'b1;
            wheel = 2'(r.device_id - ID_DRIVE_LO);
         end else begin
            // steering ids of wheels 2 and 3 are crossed
            case (r.device_id)
               ID_STEER_0: wheel = 2'd0;
               ID_STEER_1: wheel = 2'd1;
               ID_STEER_2: wheel = 2'd2;
               ID_STEER_3: wheel = 2'd3;
               default:    known = 1'b0;
            endcase
         end
         if (known) begin
            qv = predict_quality(r);
            if (drive) drive_wgt[wheel] = qv;
            else steer_wgt[wheel] = qv;
         end
         want.id_recognized = known;
         want.wheel_num     = known ? wheel : 2'd0;
         want.item_quality  = qv;
         want.weight_wheel0 = combined(0);
         want.weight_wheel1 = combined(1);
         want.weight_wheel2 = combined(2);
         want.weight_wheel3 = combined(3);
         expected_weights.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_weights.size() == 0) begin
            report_mismatch($sformatf("result %h with no report pending", got));
            return;
         end
         want = expected_weights.pop_front();
         check_field("id_recognized", 32'(got.id_recognized), 32'(want.id_recognized));
         check_field("wheel_num",     32'(got.wheel_num),     32'(want.wheel_num));
         check_field("item_quality",  32'(got.item_quality),  32'(want.item_quality));
         check_field("weight_wheel0", 32'(got.weight_wheel0), 32'(want.weight_wheel0));
         check_field("weight_wheel1", 32'(got.weight_wheel1), 32'(want.weight_wheel1));
         check_field("weight_wheel2", 32'(got.weight_wheel2), 32'(want.weight_wheel2));
         check_field("weight_wheel3", 32'(got.weight_wheel3), 32'(want.weight_wheel3));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // idle odds in percent per cycle, and the receiver's long hold-off counter
   int sender_idle   = 0;
   int receiver_idle = 0;
   int hold_cycles   = 0;

   logic [7:0] known_ids [8] = '{ID_DRIVE_LO, ID_DRIVE_LO + 8'd1, ID_DRIVE_LO + 8'd2,
                                 ID_DRIVE_HI, ID_STEER_0, ID_STEER_1, ID_STEER_2,
                                 ID_STEER_3};
   logic [7:0] stray_ids [6] = '{8'h00, ID_DRIVE_LO - 8'd1, ID_DRIVE_HI + 8'd1,
                                 ID_STEER_0 - 8'd1, ID_STEER_2 + 8'd1, 8'hFF};

   wheel_weight_tracker tracker = new();

   wheel_feedback_quality_weighting_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random back-pressure, or a counted long hold-off when asked.
   // Drives at the falling edge so the DUT sees a settled rsp_ready.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= receiver_idle);
      end
   end

   // Result monitor: a transaction completes at a rising edge with valid and ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
   end

   // ------------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------------

   // Drop valid and wait until every outstanding report has produced its result.
   // A few spare cycles let the core settle back to idle before any register write.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.expected_weights.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Registers only change with the core idle
   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      wait_for_results();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Offer one report; valid stays up, payload unchanged, until the transaction.
   // Valid is left high afterwards so back-to-back reports need no glitch.
   task automatic send_report(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      tracker.note_report(r);
   endtask

   function automatic req_type make_report(logic [7:0] id, longint rpm,
                                           int cur, int duty);
      req_type r;
      r.device_id      = id;
      r.electrical_rpm = 32'(rpm);
      r.motor_current  = 16'(cur);
      r.duty_q15       = 16'(duty);
      return r;
   endfunction

   // Mostly known ids at low speed with current and duty around their knees,
   // so most reports go through the divider; the rest is full-range noise.
   function automatic req_type random_report();
      req_type     r;
      logic [31:0] mag;
      logic [15:0] knee;
      if ($urandom_range(9) < 8) r.device_id = known_ids[$urandom_range(7)];
      else r.device_id = 8'($urandom);
      case ($urandom_range(7))
         0:       mag = $urandom;
         1:       mag = 32'h8000_0000;
         2:       mag = tracker.rpm_thr - 32'($urandom_range(1));
         default: mag = 32'($urandom_range(1500));
      endcase
      r.electrical_rpm = $urandom_range(1) ? -mag : mag;
      if ($urandom_range(2) == 0) begin
         r.motor_current = 16'($urandom);
      end else begin
         knee = 16'(tracker.cur_thr) + 16'($urandom_range(2000)) - 16'd1000;
         r.motor_current = $urandom_range(1) ? -knee : knee;
      end
      if ($urandom_range(2) == 0) begin
         r.duty_q15 = 16'($urandom);
      end else begin
         knee = 16'(tracker.duty_thr) + 16'($urandom_range(4000)) - 16'd2000;
         r.duty_q15 = $urandom_range(1) ? -knee : knee;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [31:0] thr;
      logic [14:0] knee15;
      logic [15:0] floor_w;

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // --- directed, reset settings ---
      send_report(make_report(ID_DRIVE_LO, 0, 0, 0));                 // no penalty
      send_report(make_report(ID_DRIVE_LO + 8'd1, 0, -32768, -32768)); // both minimum codes
      send_report(make_report(ID_DRIVE_LO + 8'd2, 999, 32767, 32767));
      send_report(make_report(ID_DRIVE_HI, 1000, 5000, 32000));        // rpm right at threshold
      send_report(make_report(ID_STEER_0, -1000, 5000, 32000));        // negative rpm at threshold
      send_report(make_report(ID_STEER_1, 32'h8000_0000, -5000, 0));
      send_report(make_report(ID_STEER_3, 32'h7FFF_FFFF, 0, 0));
      send_report(make_report(ID_STEER_2, -999, 3001, -29492));        // one past each knee
      send_report(make_report(ID_STEER_2, 0, -3000, 29491));           // exactly on the knees
      // ids just outside each mapped range: nothing may change
      foreach (stray_ids[i]) send_report(make_report(stray_ids[i], 0, -32768, -32768));

      // --- directed, register corners ---
      write_csr(CSR_ENABLE, 32'hFFFF_FFFE);   // weighting off, upper bits ignored
      send_report(make_report(ID_DRIVE_LO, 0, -32768, -32768));
      write_csr(CSR_ENABLE, 32'h0000_0001);
      write_csr(CSR_RPM_THR, 32'd0);          // every report at full quality
      send_report(make_report(ID_STEER_1, 0, 32767, 32767));
      write_csr(CSR_RPM_THR, 32'hFFFF_FFFF);
      write_csr(CSR_CUR_THR, 32'hFFFF_8000);  // low bits zero: current knee acts as 1
      write_csr(CSR_DUTY_THR, 32'h0001_8000); // low bits zero: duty knee acts as 1
      write_csr(CSR_MIN_WGT, 32'hFFFF_0000);  // no floor
      send_report(make_report(ID_DRIVE_LO + 8'd2, 32'h8000_0000, -32768, -32768));
      send_report(make_report(ID_STEER_0, 5, 2, 2));
      write_csr(CSR_CUR_THR, 32'h0000_7FFF);
      write_csr(CSR_DUTY_THR, 32'h0000_7FFF);
      write_csr(CSR_MIN_WGT, 32'h0000_8000);  // floor of exactly 1.0
      send_report(make_report(ID_DRIVE_HI, 0, -32768, -32768));
      write_csr(CSR_MIN_WGT, 32'h0000_FFFF);  // floor above 1.0 saturates to 1.0
      send_report(make_report(ID_STEER_2, 0, 32767, -32768));
      // writes past the register list must not disturb anything
      for (int i = CSR_MIN_WGT + 1; i < 2 ** $bits(csr_index); i++) write_csr(3'(i), '0);
      send_report(make_report(ID_STEER_3, 0, -32768, -32768));
      write_csr(CSR_MIN_WGT, 32'd0);
      send_report(make_report(ID_STEER_1, 999, -32768, -32768));

      // back to reset settings for the first random phase
      write_csr(CSR_ENABLE, 32'd1);
      write_csr(CSR_RPM_THR, 32'd1000);
      write_csr(CSR_CUR_THR, 32'd3000);
      write_csr(CSR_DUTY_THR, 32'd29491);
      write_csr(CSR_MIN_WGT, 32'd3277);

      // --- random phases: slow receiver, then slow sender, then full rate ---
      for (int phase = 0; phase < 9; phase++) begin
         sender_idle   = (phase < 3) ? 6 : (phase < 6) ? 76 : 0;
         receiver_idle = (phase < 3) ? 76 : (phase < 6) ? 6 : 0;
         if (phase != 0) begin
            write_csr(CSR_ENABLE, {31'($urandom), 1'(phase != 4)});
            case ($urandom_range(9))
               0:       thr = 32'd0;
               1:       thr = 32'hFFFF_FFFF;
               2:       thr = 32'h8000_0000;
               3:       thr = $urandom;
               default: thr = 32'($urandom_range(1, 100000));
            endcase
            write_csr(CSR_RPM_THR, thr);
            case ($urandom_range(5))
               0:       knee15 = 15'd0;
               1:       knee15 = 15'd1;
               2:       knee15 = 15'h7FFF;
               default: knee15 = 15'($urandom_range(1, 8000));
            endcase
            write_csr(CSR_CUR_THR, {17'($urandom), knee15});
            case ($urandom_range(5))
               0:       knee15 = 15'd0;
               1:       knee15 = 15'd1;
               2:       knee15 = 15'h7FFF;
               default: knee15 = 15'($urandom_range(16384, 32767));
            endcase
            write_csr(CSR_DUTY_THR, {17'($urandom), knee15});
            case ($urandom_range(5))
               0:       floor_w = 16'd0;
               1:       floor_w = Q_ONE;
               2:       floor_w = 16'hFFFF;
               default: floor_w = 16'($urandom_range(20000));
            endcase
            write_csr(CSR_MIN_WGT, {16'($urandom), floor_w});
         end
         // long receiver stall while the sender keeps offering: the core fills
         // up and must hold req_ready low until the stall ends
         if (phase == 1 || phase == 7) hold_cycles = 400;
         for (int n = 0; n < 210; n++) begin
            if (n % 70 == 69) wait_for_results();   // sender pauses until drained
            send_report(random_report());
         end
      end

      // drain, then a short tail to catch any stray result
      wait_for_results();
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
